// ----- rtl/wfpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared constants, codes and request types of the worst-fit partition
// allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    // Table geometry (MAX_PROCESSES is a power of two: ids wrap by truncation)
    localparam int NUM_BLOCKS    = 16;
    localparam int MAX_PROCESSES = 64;
    localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PID_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // Field and bus widths
    localparam int SIZE_W  = 16;
    localparam int FREE_W  = 20;
    localparam int BIU_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;
    localparam int ID_W    = 6;
    localparam int STAT_W  = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_LOADED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXT_FRAG = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd3;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    // Register map (word index) and reset value
    localparam logic [ADDR_W-3:0] REG_BIU   = 1'b0;
    localparam logic [BIU_W-1:0]  BIU_RESET = 5'd16;

    // Partition size store access
    typedef struct packed {
        logic              we;
        logic [BLK_W-1:0]  waddr;
        logic [SIZE_W-1:0] wdata;
        logic              re;
        logic [BLK_W-1:0]  raddr;
    } t_size_req;

    // Owner table access
    typedef struct packed {
        logic             we;
        logic             clr;
        logic [PID_W-1:0] waddr;
        logic [BLK_W-1:0] wdata;
        logic             re;
        logic [PID_W-1:0] raddr;
    } t_own_req;

    typedef struct packed {
        logic             vld;
        logic [BLK_W-1:0] part;
    } t_own_rsp;

endpackage

// ----- rtl/wfpa_size_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_size_store
// Partition size memory: one write and one registered read per cycle. An
// entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module wfpa_size_store import wfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_size_req         i_req,
    output logic [SIZE_W-1:0] o_rdata
);

    logic [SIZE_W-1:0]     r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [SIZE_W-1:0]     r_rdata;

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read, unwritten entries give zero
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_vld[i_req.raddr] ? r_mem[i_req.raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wfpa_owner_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_owner_store
// Process-to-partition table: one write or clear and one registered read per
// cycle. An entry without its valid bit means no partition held.
// ----------------------------------------------------------------------------
module wfpa_owner_store import wfpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_own_req i_req,
    output t_own_rsp o_rsp
);

    logic [BLK_W-1:0]         r_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] r_vld;
    t_own_rsp                 r_rsp;

    // Valid bits: set on grant, drop on release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end else if (i_req.clr) begin
            r_vld[i_req.waddr] <= 1'b0;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rsp.vld  <= r_vld[i_req.raddr];
            r_rsp.part <= r_mem[i_req.raddr];
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- rtl/worst_fit_partition_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Fixed-partition worst-fit allocator. Sizes and owners live in two small
// synchronous memories; a sequencer releases, evicts, scans and grants.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  action, block_index, size_value,
//                                              process_id, victim_process
//   out      output     o_out_valid/i_out_stall status, granted_block,
//                                              internal_fragment,
//                                              free_space_now, evicted,
//                                              evicted_block
//   cfg      input      APB (psel, penable)    blocks_in_use at address 0
//
// The allocate scan reads one partition size per cycle from the size memory
// port, over the number of partitions in use.
// One item is worked on at a time; the next is taken while a result waits.
// A result held by i_out_stall delays only the final update of the next item.
// Reset clears all tables at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator import wfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [IDX_W-1:0]  i_block_index,
    input  logic [SIZE_W-1:0] i_size_value,
    input  logic [ID_W-1:0]   i_process_id,
    input  logic [ID_W-1:0]   i_victim_process,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_granted_block,
    output logic [SIZE_W-1:0] o_internal_fragment,
    output logic [FREE_W-1:0] o_free_space_now,
    output logic              o_evicted,
    output logic [IDX_W-1:0]  o_evicted_block,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_OWN   = 4'd2;
    localparam logic [3:0] S_REL   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_VIC   = 4'd5;
    localparam logic [3:0] S_VREL  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_GRANT = 4'd8;

    // Control state
    logic [3:0]            r_state, n_state;
    logic [BIU_W-1:0]      r_biu;
    logic [FREE_W-1:0]     r_free, n_free;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [NUM_BLOCKS-1:0] r_taken, n_taken;
    logic [CNT_W-1:0]      r_j, n_j;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_best_vld, n_best_vld;
    logic                  r_ev, n_ev;
    logic                  r_out_valid, n_out_valid;

    // Item and working payload
    logic [IDX_W-1:0]      r_bidx, n_bidx;
    logic [SIZE_W-1:0]     r_sz, n_sz;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic [PID_W-1:0]      r_vic, n_vic;
    logic [BLK_W-1:0]      r_rel, n_rel;
    logic [BLK_W-1:0]      r_evb, n_evb;
    logic [BLK_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic [BLK_W-1:0]      r_best_idx, n_best_idx;
    logic [SIZE_W-1:0]     r_best_size, n_best_size;

    // Result register
    logic [STAT_W-1:0]     r_status, n_status;
    logic [IDX_W-1:0]      r_grant, n_grant;
    logic [SIZE_W-1:0]     r_frag, n_frag;
    logic [FREE_W-1:0]     r_free_out, n_free_out;
    logic                  r_ev_out, n_ev_out;
    logic [IDX_W-1:0]      r_evb_out, n_evb_out;

    t_size_req             w_size_req;
    logic [SIZE_W-1:0]     w_size_rdata;
    t_own_req              w_own_req;
    t_own_rsp              w_own_rsp;
    logic [CNT_W-1:0]      w_lim;
    logic                  w_slot;
    logic                  w_bidx_ok;
    logic                  w_cfg_wr;

    wfpa_size_store u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_size_req),
        .o_rdata (w_size_rdata)
    );

    wfpa_owner_store u_owner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_own_req),
        .o_rsp   (w_own_rsp)
    );

    // Configuration register
    assign w_cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BIU);
    assign pready   = 1'b1;
    assign prdata   = (paddr[ADDR_W-1:2] == REG_BIU) ? DATA_W'(r_biu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= BIU_RESET;
        end else if (w_cfg_wr) begin
            r_biu <= pwdata[BIU_W-1:0];
        end
    end

    // Partitions taking part, clamped to the table
    assign w_lim = (int'(r_biu) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(r_biu);
    assign w_bidx_ok = int'(r_bidx) < NUM_BLOCKS;
    // Result register can take a new item this cycle
    assign w_slot = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_cnt       = r_cnt;
        n_taken     = r_taken;
        n_j         = r_j;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_best_vld  = r_best_vld;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_ev        = r_ev;
        n_evb       = r_evb;
        n_rel       = r_rel;
        n_bidx      = r_bidx;
        n_sz        = r_sz;
        n_pid       = r_pid;
        n_vic       = r_vic;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_grant     = r_grant;
        n_frag      = r_frag;
        n_free_out  = r_free_out;
        n_ev_out    = r_ev_out;
        n_evb_out   = r_evb_out;
        w_size_req  = '0;
        w_own_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_bidx     = i_block_index;
                    n_sz       = i_size_value;
                    n_pid      = PID_W'(i_process_id);
                    n_vic      = PID_W'(i_victim_process);
                    n_ev       = 1'b0;
                    n_evb      = '0;
                    n_best_vld = 1'b0;
                    n_j        = '0;
                    if (i_action == ACT_LOAD) begin
                        w_size_req.re    = 1'b1;
                        w_size_req.raddr = BLK_W'(i_block_index);
                        n_state          = S_LOAD;
                    end else begin
                        w_own_req.re    = 1'b1;
                        w_own_req.raddr = PID_W'(i_process_id);
                        n_state         = S_OWN;
                    end
                end
            end

            // Replace the size; a free partition moves the free total
            S_LOAD: begin
                if (w_slot) begin
                    if (w_bidx_ok) begin
                        w_size_req.we    = 1'b1;
                        w_size_req.waddr = BLK_W'(r_bidx);
                        w_size_req.wdata = r_sz;
                        if (!r_taken[BLK_W'(r_bidx)]) begin
                            n_free = r_free + FREE_W'(r_sz) - FREE_W'(w_size_rdata);
                        end
                    end
                    n_out_valid = 1'b1;
                    n_status    = ST_LOADED;
                    n_grant     = '0;
                    n_frag      = '0;
                    n_free_out  = n_free;
                    n_ev_out    = 1'b0;
                    n_evb_out   = '0;
                    n_state     = S_IDLE;
                end
            end

            // Requester already holds a partition: drop it
            S_OWN: begin
                if (w_own_rsp.vld) begin
                    w_size_req.re    = 1'b1;
                    w_size_req.raddr = w_own_rsp.part;
                    w_own_req.clr    = 1'b1;
                    w_own_req.waddr  = r_pid;
                    n_rel            = w_own_rsp.part;
                    n_state          = S_REL;
                end else begin
                    n_state = S_CHK;
                end
            end

            // Release a partition (own or victim's)
            S_REL, S_VREL: begin
                if (r_taken[r_rel]) begin
                    n_taken[r_rel] = 1'b0;
                    n_free         = r_free + FREE_W'(w_size_rdata);
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
                n_state = (r_state == S_REL) ? S_CHK : S_SCAN;
            end

            // All partitions in use taken: look up the victim
            S_CHK: begin
                if (r_cnt >= w_lim) begin
                    w_own_req.re    = 1'b1;
                    w_own_req.raddr = r_vic;
                    n_state         = S_VIC;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_VIC: begin
                w_own_req.clr   = 1'b1;
                w_own_req.waddr = r_vic;
                if (w_own_rsp.vld) begin
                    w_size_req.re    = 1'b1;
                    w_size_req.raddr = w_own_rsp.part;
                    n_rel            = w_own_rsp.part;
                    n_ev             = 1'b1;
                    n_evb            = w_own_rsp.part;
                    n_state          = S_VREL;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // Read one size per cycle, compare the one read last cycle
            S_SCAN: begin
                if (r_cmp_vld && !r_taken[r_cmp_idx] && (w_size_rdata >= r_sz) &&
                    (!r_best_vld || (r_best_size < w_size_rdata))) begin
                    n_best_vld  = 1'b1;
                    n_best_idx  = r_cmp_idx;
                    n_best_size = w_size_rdata;
                end
                if (r_j < w_lim) begin
                    w_size_req.re    = 1'b1;
                    w_size_req.raddr = r_j[BLK_W-1:0];
                    n_cmp_vld        = 1'b1;
                    n_cmp_idx        = r_j[BLK_W-1:0];
                    n_j              = r_j + 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state = S_GRANT;
                end
            end

            // Grant the largest fit or report the failure
            S_GRANT: begin
                if (w_slot) begin
                    if (r_best_vld) begin
                        w_own_req.we     = 1'b1;
                        w_own_req.waddr  = r_pid;
                        w_own_req.wdata  = r_best_idx;
                        n_taken[r_best_idx] = 1'b1;
                        n_free           = r_free - FREE_W'(r_best_size);
                        n_cnt            = r_cnt + 1'b1;
                        n_status         = ST_ALLOC;
                        n_grant          = IDX_W'(r_best_idx);
                        n_frag           = r_best_size - r_sz;
                    end else begin
                        n_status = (r_free >= FREE_W'(r_sz)) ? ST_EXT_FRAG : ST_NO_MEM;
                        n_grant  = '0;
                        n_frag   = '0;
                    end
                    n_out_valid = 1'b1;
                    n_free_out  = n_free;
                    n_ev_out    = r_ev;
                    n_evb_out   = IDX_W'(r_evb);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_cnt       <= '0;
            r_taken     <= '0;
            r_j         <= '0;
            r_cmp_vld   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_cnt       <= n_cnt;
            r_taken     <= n_taken;
            r_j         <= n_j;
            r_cmp_vld   <= n_cmp_vld;
            r_best_vld  <= n_best_vld;
            r_ev        <= n_ev;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bidx      <= n_bidx;
        r_sz        <= n_sz;
        r_pid       <= n_pid;
        r_vic       <= n_vic;
        r_rel       <= n_rel;
        r_evb       <= n_evb;
        r_cmp_idx   <= n_cmp_idx;
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
        r_status    <= n_status;
        r_grant     <= n_grant;
        r_frag      <= n_frag;
        r_free_out  <= n_free_out;
        r_ev_out    <= n_ev_out;
        r_evb_out   <= n_evb_out;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_granted_block     = r_grant;
    assign o_internal_fragment = r_frag;
    assign o_free_space_now    = r_free_out;
    assign o_evicted           = r_ev_out;
    assign o_evicted_block     = r_evb_out;

endmodule

// ----- rtl/wfpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_checker
// Port-level checks of the worst-fit partition allocator, bound to the top.
// ----------------------------------------------------------------------------
module wfpa_checker import wfpa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [IDX_W-1:0]  o_granted_block,
    input logic [SIZE_W-1:0] o_internal_fragment,
    input logic              o_evicted,
    input logic [IDX_W-1:0]  o_evicted_block,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata
);

    // An accepted item occupies the block for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_granted_block) && $stable(o_internal_fragment))
        else $error("stalled result changed");

    // Grant fields are zero unless a partition was granted
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ALLOC) |->
        (o_granted_block == '0) && (o_internal_fragment == '0))
        else $error("grant fields set without allocation");

    // Eviction only on allocate, and its block is zero otherwise
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_evicted ? (o_status != ST_LOADED) : (o_evicted_block == '0)))
        else $error("eviction fields inconsistent");

    // A register write reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr == '0) |=>
        (paddr != '0) || (prdata[BIU_W-1:0] == $past(pwdata[BIU_W-1:0])))
        else $error("register readback mismatch");

endmodule

bind worst_fit_partition_allocator wfpa_checker u_wfpa_checker (.*);

// ----- tb/tb_worst_fit_partition_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_worst_fit_partition_allocator
// Self-checking bench for the worst-fit partition allocator. A directed plan
// covers the reset state, the size extremes, the failure codes, loads of
// taken partitions, a requester that already holds a partition, victims with
// and without a partition, and out-of-range partition counts. Random traffic
// then runs under several partition counts and flow-control patterns. Every
// result is compared field by field with a behavioural allocator held here.
// ----------------------------------------------------------------------------
module tb_worst_fit_partition_allocator;
    import wfpa_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 94;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 24;
    localparam logic [ADDR_W-1:0] BIU_ADDR = {REG_BIU, 2'b00};
    // Partition count per random phase: extremes 0, 1, 16 and 31 among them
    localparam logic [PHASES*BIU_W-1:0] PHASE_BIU =
        {5'd16, 5'd3, 5'd8, 5'd0, 5'd31, 5'd4, 5'd1, 5'd16};

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  granted_block;
        logic [SIZE_W-1:0] internal_fragment;
        logic [FREE_W-1:0] free_space_now;
        logic              evicted;
        logic [IDX_W-1:0]  evicted_block;
    } t_result;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              act;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   vic;
        logic [BIU_W-1:0]  biu;
        t_result           res;
    } t_plan_row;

    // DUT inputs, known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_action = 1'b0;
    logic [IDX_W-1:0]  i_block_index = '0;
    logic [SIZE_W-1:0] i_size_value = '0;
    logic [ID_W-1:0]   i_process_id = '0;
    logic [ID_W-1:0]   i_victim_process = '0;
    logic              i_out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;

    // DUT outputs
    logic              o_in_stall;
    logic              o_out_valid;
    logic [STAT_W-1:0] o_status;
    logic [IDX_W-1:0]  o_granted_block;
    logic [SIZE_W-1:0] o_internal_fragment;
    logic [FREE_W-1:0] o_free_space_now;
    logic              o_evicted;
    logic [IDX_W-1:0]  o_evicted_block;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Allocator state as the bench sees it
    logic [SIZE_W-1:0] blk_size [NUM_BLOCKS];
    logic              blk_taken [NUM_BLOCKS];
    logic              owner_vld [MAX_PROCESSES];
    logic [IDX_W-1:0]  owner_blk [MAX_PROCESSES];
    logic [FREE_W-1:0] free_total;
    int                taken_count;
    logic [BIU_W-1:0]  cfg_biu;

    t_result   expected_grants [$];
    t_plan_row plan [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int loads_sent     = 0;
    int evictions_seen = 0;
    int settings_seen  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    worst_fit_partition_allocator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_block_index      (i_block_index),
        .i_size_value       (i_size_value),
        .i_process_id       (i_process_id),
        .i_victim_process   (i_victim_process),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_granted_block    (o_granted_block),
        .o_internal_fragment(o_internal_fragment),
        .o_free_space_now   (o_free_space_now),
        .o_evicted          (o_evicted),
        .o_evicted_block    (o_evicted_block),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_grants.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    function automatic void clear_model();
        int k;
        for (k = 0; k < NUM_BLOCKS; k++) begin
            blk_size[k]  = '0;
            blk_taken[k] = 1'b0;
        end
        for (k = 0; k < MAX_PROCESSES; k++) begin
            owner_vld[k] = 1'b0;
            owner_blk[k] = '0;
        end
        free_total  = '0;
        taken_count = 0;
        cfg_biu     = BIU_RESET;
    endfunction

    // Return a taken partition to the free pool
    function automatic void release_block(input logic [IDX_W-1:0] blk);
        if (blk_taken[blk]) begin
            blk_taken[blk] = 1'b0;
            free_total = free_total + blk_size[blk];
            if (taken_count > 0)
                taken_count--;
        end
    endfunction

    // Apply one item to the bench allocator and return the result it causes
    function automatic t_result worst_fit_step(input logic act,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [SIZE_W-1:0] sz,
                                               input logic [ID_W-1:0] pid,
                                               input logic [ID_W-1:0] vic);
        t_result           r;
        logic [FREE_W-1:0] sz_w;
        int                lim;
        int                best;
        int                j;
        r    = '0;
        sz_w = sz;
        if (act == ACT_LOAD) begin
            // Free partitions move the free total by the size difference
            if (!blk_taken[idx])
                free_total = free_total + sz_w - blk_size[idx];
            blk_size[idx] = sz;
            r.status = ST_LOADED;
        end else begin
            lim  = (cfg_biu > NUM_BLOCKS) ? NUM_BLOCKS : int'(cfg_biu);
            best = -1;
            // Drop the requester's own partition first, silently
            if (owner_vld[pid]) begin
                release_block(owner_blk[pid]);
                owner_vld[pid] = 1'b0;
            end
            // Swap out the victim when every participating partition is taken
            if (taken_count >= lim) begin
                if (owner_vld[vic]) begin
                    release_block(owner_blk[vic]);
                    r.evicted       = 1'b1;
                    r.evicted_block = owner_blk[vic];
                    evictions_seen++;
                end
                owner_vld[vic] = 1'b0;
            end
            // Largest free fit, lowest index on a tie
            for (j = 0; j < lim; j++) begin
                if (!blk_taken[j] && blk_size[j] >= sz) begin
                    if (best < 0 || blk_size[best] < blk_size[j])
                        best = j;
                end
            end
            if (best >= 0) begin
                owner_vld[pid]  = 1'b1;
                owner_blk[pid]  = best[IDX_W-1:0];
                blk_taken[best] = 1'b1;
                free_total      = free_total - blk_size[best];
                taken_count++;
                r.status            = ST_ALLOC;
                r.granted_block     = best[IDX_W-1:0];
                r.internal_fragment = blk_size[best] - sz;
            end else begin
                r.status = (free_total >= sz_w) ? ST_EXT_FRAG : ST_NO_MEM;
            end
        end
        r.free_space_now = free_total;
        return r;
    endfunction

    // Plan builders for the directed part
    function automatic void add_cfg(input logic [BIU_W-1:0] v);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.biu  = v;
        plan.push_back(row);
    endfunction

    function automatic void add_item(input logic act, input logic [IDX_W-1:0] idx,
                                     input logic [SIZE_W-1:0] sz,
                                     input logic [ID_W-1:0] pid,
                                     input logic [ID_W-1:0] vic);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.act  = act;
        row.idx  = idx;
        row.sz   = sz;
        row.pid  = pid;
        row.vic  = vic;
        plan.push_back(row);
    endfunction

    // Item with its result typed in; no eviction in any of these rows
    function automatic void add_checked(input logic act, input logic [IDX_W-1:0] idx,
                                        input logic [SIZE_W-1:0] sz,
                                        input logic [ID_W-1:0] pid,
                                        input logic [ID_W-1:0] vic,
                                        input logic [STAT_W-1:0] st,
                                        input logic [IDX_W-1:0] gb,
                                        input logic [SIZE_W-1:0] frag,
                                        input logic [FREE_W-1:0] free);
        add_item(act, idx, sz, pid, vic);
        plan[$].kind                  = ROW_CHECKED;
        plan[$].res.status            = st;
        plan[$].res.granted_block     = gb;
        plan[$].res.internal_fragment = frag;
        plan[$].res.free_space_now    = free;
    endfunction

    // Offer one item, hold it until taken, then record what it should give
    task automatic push_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] sz, input logic [ID_W-1:0] pid,
                             input logic [ID_W-1:0] vic, input logic typed,
                             input t_result typed_res);
        t_result r;
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_block_index    <= idx;
        i_size_value     <= sz;
        i_process_id     <= pid;
        i_victim_process <= vic;
        do @(posedge i_clk); while (o_in_stall);
        r = worst_fit_step(act, idx, sz, pid, vic);
        expected_grants.push_back(typed ? typed_res : r);
        items_sent++;
        if (act == ACT_LOAD)
            loads_sent++;
    endtask

    // Drop valid and wait for every outstanding result, then settle
    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write the partition count over APB, then read it back
    task automatic write_blocks_in_use(input logic [BIU_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIU_ADDR;
        pwdata  <= DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_biu = v;
        settings_seen++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(v))
            note_mismatch($sformatf("blocks_in_use read back %0h, expected %0h",
                                    prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 2000));
        endcase
    endfunction

    // Random item biased towards partitions and processes that matter
    task automatic send_random_item();
        logic              act;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        logic [ID_W-1:0]   pid;
        logic [ID_W-1:0]   vic;
        int                lim;
        int                pool;
        int                start;
        int                k;
        bit                found;
        lim   = (cfg_biu > NUM_BLOCKS) ? NUM_BLOCKS : int'(cfg_biu);
        pool  = lim + 4;
        act   = ($urandom_range(0, 99) < 35) ? ACT_LOAD : ACT_ALLOC;
        if (lim != 0 && $urandom_range(0, 3) != 0)
            idx = IDX_W'($urandom_range(0, lim - 1));
        else
            idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        sz    = pick_size();
        if ($urandom_range(0, 4) != 0)
            pid = ID_W'($urandom_range(0, pool - 1));
        else
            pid = ID_W'($urandom_range(0, MAX_PROCESSES - 1));
        vic   = ID_W'($urandom_range(0, pool - 1));
        found = 1'b0;
        // Mostly name a victim that really holds a partition
        if ($urandom_range(0, 9) < 6) begin
            start = $urandom_range(0, MAX_PROCESSES - 1);
            for (k = 0; k < MAX_PROCESSES; k++) begin
                if (!found && owner_vld[(start + k) % MAX_PROCESSES]) begin
                    vic   = ID_W'((start + k) % MAX_PROCESSES);
                    found = 1'b1;
                end
            end
        end
        if ($urandom_range(0, 19) == 0)
            vic = ID_W'($urandom_range(0, MAX_PROCESSES - 1));
        push_item(act, idx, sz, pid, vic, 1'b0, '0);
    endtask

    // Check results
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_granted_block, o_internal_fragment,
                   o_free_space_now, o_evicted, o_evicted_block};
            results_seen++;
            if (expected_grants.size() == 0) begin
                note_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = expected_grants.pop_front();
                if (got.status !== want.status
                        || got.granted_block !== want.granted_block
                        || got.internal_fragment !== want.internal_fragment
                        || got.free_space_now !== want.free_space_now
                        || got.evicted !== want.evicted
                        || got.evicted_block !== want.evicted_block)
                    note_mismatch($sformatf(
                        "result %0d: exp st=%0d gb=%0d fr=%0d free=%0d ev=%0d evb=%0d%s",
                        results_seen, want.status, want.granted_block,
                        want.internal_fragment, want.free_space_now, want.evicted,
                        want.evicted_block,
                        $sformatf(" / got st=%0d gb=%0d fr=%0d free=%0d ev=%0d evb=%0d",
                                  got.status, got.granted_block, got.internal_fragment,
                                  got.free_space_now, got.evicted, got.evicted_block)));
            end
        end
    end

    // Drive the receiver's stall; hold off once for a long stretch
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (recv_stall_pct != 0)
                           && ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // Reset, directed plan, random phases, wrap-up
    initial begin
        int r;
        int ph;
        int n;
        clear_model();

        // Reset state, extremes and the failure codes
        add_checked(ACT_ALLOC, 0, 16'd1, 6'd1, 6'd0, ST_NO_MEM, 0, 0, 0);
        add_checked(ACT_ALLOC, 0, 16'd0, 6'd2, 6'd0, ST_ALLOC, 0, 0, 0);
        add_checked(ACT_LOAD, 15, 16'hFFFF, 6'd0, 6'd0, ST_LOADED, 0, 0, 20'd65535);
        // Load of a taken partition leaves the free total alone
        add_checked(ACT_LOAD, 0, 16'hFFFF, 6'd0, 6'd0, ST_LOADED, 0, 0, 20'd65535);
        add_checked(ACT_LOAD, 3, 16'd100, 6'd0, 6'd0, ST_LOADED, 0, 0, 20'd65635);
        add_checked(ACT_ALLOC, 0, 16'hFFFF, 6'd63, 6'd63, ST_ALLOC, 15, 0, 20'd100);
        add_checked(ACT_ALLOC, 0, 16'd200, 6'd5, 6'd0, ST_NO_MEM, 0, 0, 20'd100);
        add_checked(ACT_LOAD, 4, 16'd150, 6'd63, 6'd63, ST_LOADED, 0, 0, 20'd250);
        add_checked(ACT_ALLOC, 15, 16'd200, 6'd5, 6'd0, ST_EXT_FRAG, 0, 0, 20'd250);
        // Requester that already holds a partition
        add_item(ACT_ALLOC, 0, 16'd50, 6'd63, 6'd0);
        add_checked(ACT_LOAD, 15, 16'd10, 6'd0, 6'd0, ST_LOADED, 0, 0, 20'd250);
        // Full with two partitions: victim without a partition, then with one
        add_cfg(5'd2);
        add_checked(ACT_ALLOC, 0, 16'd1, 6'd7, 6'd9, ST_EXT_FRAG, 0, 0, 20'd250);
        add_item(ACT_ALLOC, 0, 16'd60000, 6'd7, 6'd2);
        // No partition takes part: always full, every allocate fails
        add_cfg(5'd0);
        add_item(ACT_ALLOC, 0, 16'd0, 6'd8, 6'd7);
        add_item(ACT_ALLOC, 0, 16'hFFFF, 6'd8, 6'd40);
        // Count above the partition total acts as all partitions; tie on size
        add_cfg(5'd31);
        add_item(ACT_LOAD, 5, 16'hFFFF, 6'd0, 6'd0);
        add_item(ACT_ALLOC, 9, 16'd0, 6'd33, 6'd1);
        add_item(ACT_ALLOC, 0, 16'hFFFF, 6'd34, 6'd1);
        add_item(ACT_ALLOC, 0, 16'hFFFF, 6'd35, 6'd33);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_CFG) begin
                wait_drained(SETTLE_CYCLES);
                write_blocks_in_use(plan[r].biu);
            end else begin
                push_item(plan[r].act, plan[r].idx, plan[r].sz, plan[r].pid,
                          plan[r].vic, plan[r].kind == ROW_CHECKED, plan[r].res);
            end
        end

        // Random phases, each with its own partition count and flow pattern
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained(SETTLE_CYCLES);
            write_blocks_in_use(PHASE_BIU[ph*BIU_W +: BIU_W]);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender once until the block has answered everything
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_drained(2);
                send_random_item();
            end
        end

        wait_drained(2 * SETTLE_CYCLES);
        $display("Covered %0d items (%0d loads) over %0d partition-count settings,",
                 items_sent, loads_sent, settings_seen);
        $display("with %0d evictions, %0d results checked, %0d mismatches.",
                 evictions_seen, results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_grants.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
